### rtl/core/ppc_pkg.sv
`default_nettype none
package ppc_pkg;

    // coding direction
    typedef enum logic {
        MODE_FWD = 1'b0,
        MODE_INV = 1'b1
    } t_mode;

    // configuration register indexes
    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;
    localparam logic [1:0] CFG_DEPTH  = 2'd3;

    // fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int IMG_W_W  = 13;
    localparam int IMG_H_W  = 16;
    localparam int DEPTH_W  = 5;

    // reset values of the configuration registers
    localparam logic [IMG_W_W-1:0] RST_WIDTH  = 13'd4096;
    localparam logic [IMG_H_W-1:0] RST_HEIGHT = 16'd1;
    localparam logic [DEPTH_W-1:0] RST_DEPTH  = 5'd8;

    // raster position flags of one item
    typedef struct packed {
        logic first_col;
        logic first_row;
        logic last;
    } t_pos;

endpackage
`default_nettype wire

### rtl/core/ppc_ram.sv
`default_nettype none
module ppc_ram #(
    parameter int WIDTH     = 16,
    parameter int DEPTH     = 4096,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [ADDR_BITS-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]     i_wdata,
    input  wire logic                 i_re,
    input  wire logic [ADDR_BITS-1:0] i_raddr,
    output logic      [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first, registered read that holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### rtl/core/ppc_scan.sv
`default_nettype none
module ppc_scan #(
    parameter int MAX_WIDTH = 4096,
    parameter int ADDR_BITS = $clog2(MAX_WIDTH)
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_step,
    input  wire logic [ppc_pkg::IMG_W_W-1:0]    i_image_width,
    input  wire logic [ppc_pkg::IMG_H_W-1:0]    i_image_height,
    output logic      [ADDR_BITS-1:0]           o_addr,
    output ppc_pkg::t_pos                       o_pos
);
    import ppc_pkg::*;

    localparam int CW = (ADDR_BITS + 1 > IMG_W_W + 1) ? ADDR_BITS + 1 : IMG_W_W + 1;

    logic [ADDR_BITS-1:0] r_col, n_col;
    logic [IMG_H_W-1:0]   r_row, n_row;
    logic [CW-1:0]        w_ext, eff_w, col_inc;
    logic [IMG_H_W:0]     eff_h, row_inc;
    logic                 last_col, last_row;

    // clamp the plane width to 1..MAX_WIDTH (the row store size) and the height to at least 1
    always_comb begin
        w_ext = CW'(i_image_width);
        if (w_ext == '0) begin
            eff_w = CW'(1);
        end else if (w_ext > CW'(MAX_WIDTH)) begin
            eff_w = CW'(MAX_WIDTH);
        end else begin
            eff_w = w_ext;
        end
        eff_h = (i_image_height == '0) ? (IMG_H_W+1)'(1) : {1'b0, i_image_height};
    end

    // end-of-row and end-of-plane detection
    always_comb begin
        col_inc  = CW'(r_col) + CW'(1);
        row_inc  = {1'b0, r_row} + (IMG_H_W+1)'(1);
        last_col = (col_inc >= eff_w);
        last_row = (row_inc >= eff_h);
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : row_inc[IMG_H_W-1:0];
        end else begin
            n_col = col_inc[ADDR_BITS-1:0];
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_step) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_addr          = r_col;
    assign o_pos.first_col = (r_col == '0);
    assign o_pos.first_row = (r_row == '0);
    assign o_pos.last      = last_col && last_row;

endmodule
`default_nettype wire

### rtl/core/ppc_predict.sv
`default_nettype none
module ppc_predict #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic [SAMPLE_BITS-1:0]          i_a,
    input  wire logic [SAMPLE_BITS-1:0]          i_b,
    input  wire logic [SAMPLE_BITS-1:0]          i_c,
    input  wire logic [ppc_pkg::SAMPLE_W-1:0]    i_sample,
    input  ppc_pkg::t_mode                       i_mode,
    input  wire logic [ppc_pkg::DEPTH_W-1:0]     i_bit_depth,
    output logic      [SAMPLE_BITS-1:0]          o_orig,
    output logic      [ppc_pkg::SAMPLE_W-1:0]    o_value
);
    import ppc_pkg::*;

    localparam int PW = SAMPLE_BITS + 3;

    logic signed [PW-1:0] sa, sb, sc, d_bc, d_ac, d_p, pa, pb, pc;
    logic [SAMPLE_BITS-1:0] pred;
    logic [DEPTH_W-1:0]     depth;
    logic [SAMPLE_W-1:0]    mask, offset, pred_w, s_m, res, orig_w;

    // Paeth selection: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
    always_comb begin
        sa   = $signed({3'b000, i_a});
        sb   = $signed({3'b000, i_b});
        sc   = $signed({3'b000, i_c});
        d_bc = sb - sc;
        d_ac = sa - sc;
        d_p  = sa + sb - sc - sc;
        pa   = (d_bc < 0) ? -d_bc : d_bc;
        pb   = (d_ac < 0) ? -d_ac : d_ac;
        pc   = (d_p < 0) ? -d_p : d_p;
        if (pa <= pb && pa <= pc) begin
            pred = i_a;
        end else if (pb <= pc) begin
            pred = i_b;
        end else begin
            pred = i_c;
        end
    end

    // sample range from the bit depth, clamped to 1..SAMPLE_BITS
    always_comb begin
        if (i_bit_depth == '0) begin
            depth = DEPTH_W'(1);
        end else if (i_bit_depth > DEPTH_W'(SAMPLE_BITS)) begin
            depth = DEPTH_W'(SAMPLE_BITS);
        end else begin
            depth = i_bit_depth;
        end
        mask   = SAMPLE_W'(((SAMPLE_W+1)'(1) << depth) - (SAMPLE_W+1)'(1));
        offset = SAMPLE_W'((SAMPLE_W+1)'(1) << (depth - DEPTH_W'(1)));
    end

    // residual coding or reconstruction, modulo the range
    always_comb begin
        pred_w = SAMPLE_W'(pred);
        s_m    = i_sample & mask;
        unique case (i_mode)
            MODE_FWD: begin
                orig_w = s_m;
                res    = (s_m - pred_w + offset) & mask;
            end
            MODE_INV: begin
                orig_w = (s_m + pred_w - offset) & mask;
                res    = orig_w;
            end
            default: begin
                orig_w = s_m;
                res    = s_m;
            end
        endcase
    end

    assign o_orig  = SAMPLE_BITS'(orig_w);
    assign o_value = res;

endmodule
`default_nettype wire

### rtl/core/paeth_predictor_codec.sv
`default_nettype none
// Paeth predictor codec for one image plane in raster order.
// Configure mode, image_width, image_height and bit_depth through the
// write port while the block is idle, then stream the plane's samples on
// the input channel (valid/ready). Each input item gives exactly one
// output item: the wrapped residual (forward mode) or the rebuilt sample
// (inverse mode), with end_of_image high on the plane's last sample.
// Throughput is one item per cycle while the receiver does not stall. An
// accepted item goes to the stage 1 register, then the output register.
// The limit is the loop from the left sample through the prediction back
// into the left register, plus one row store read per item, issued on
// acceptance. The row store holds only original samples and needs no
// clearing pass; reads on the first row are masked to zero. Reset returns
// the configuration to its defaults and the position to the top-left
// corner. When the receiver stalls, the result waits in the output
// register while one more item is accepted into the prediction stage;
// the input then stalls until the output register frees up.
module paeth_predictor_codec #(
    parameter int MAX_WIDTH   = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [1:0]                        i_cfg_index,
    input  wire logic [ppc_pkg::SAMPLE_W-1:0]      i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [ppc_pkg::SAMPLE_W-1:0]      i_sample,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic      [ppc_pkg::SAMPLE_W-1:0]      o_value,
    output logic                                   o_end_of_image
);
    import ppc_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    // configuration registers
    t_mode                r_mode;
    logic [IMG_W_W-1:0]   r_image_width;
    logic [IMG_H_W-1:0]   r_image_height;
    logic [DEPTH_W-1:0]   r_bit_depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_FWD;
            r_image_width  <= RST_WIDTH;
            r_image_height <= RST_HEIGHT;
            r_bit_depth    <= RST_DEPTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODE:   r_mode         <= t_mode'(i_cfg_data[0]);
                CFG_WIDTH:  r_image_width  <= i_cfg_data[IMG_W_W-1:0];
                CFG_HEIGHT: r_image_height <= i_cfg_data[IMG_H_W-1:0];
                CFG_DEPTH:  r_bit_depth    <= i_cfg_data[DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake and stage advance
    logic in_acc, s1_adv, out_acc;
    logic r_s1_valid, r_out_valid;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_acc    = r_out_valid && i_out_ready;

    // raster position
    logic [AW-1:0] scan_addr;
    t_pos          scan_pos;

    ppc_scan #(
        .MAX_WIDTH (MAX_WIDTH),
        .ADDR_BITS (AW)
    ) u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (in_acc),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .o_addr         (scan_addr),
        .o_pos          (scan_pos)
    );

    // row store: read on acceptance, written back when stage 1 retires
    logic [AW-1:0]          r_s1_addr;
    logic [SAMPLE_BITS-1:0] ram_rdata, orig;

    ppc_ram #(
        .WIDTH     (SAMPLE_BITS),
        .DEPTH     (MAX_WIDTH),
        .ADDR_BITS (AW)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_addr),
        .i_wdata (orig),
        .i_re    (in_acc),
        .i_raddr (scan_addr),
        .o_rdata (ram_rdata)
    );

    // stage 1 registers
    logic [SAMPLE_W-1:0]    r_s1_sample;
    t_pos                   r_s1_pos;
    logic                   r_s1_fwd;
    logic [SAMPLE_BITS-1:0] r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_fwd   <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
            // same entry being written this cycle: bypass the stale read
            r_s1_fwd   <= s1_adv && (r_s1_addr == scan_addr);
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
            r_s1_fwd   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_sample <= i_sample;
            r_s1_addr   <= scan_addr;
            r_s1_pos    <= scan_pos;
            r_fwd_data  <= orig;
        end
    end

    // neighbors, zero outside the image
    logic [SAMPLE_BITS-1:0] r_left, r_upper_left;
    logic [SAMPLE_BITS-1:0] stored, nb_a, nb_b, nb_c;
    logic [SAMPLE_W-1:0]    value;

    always_comb begin
        stored = r_s1_fwd ? r_fwd_data : ram_rdata;
        nb_a   = r_s1_pos.first_col ? '0 : r_left;
        nb_b   = r_s1_pos.first_row ? '0 : stored;
        nb_c   = (r_s1_pos.first_col || r_s1_pos.first_row) ? '0 : r_upper_left;
    end

    ppc_predict #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_predict (
        .i_a         (nb_a),
        .i_b         (nb_b),
        .i_c         (nb_c),
        .i_sample    (r_s1_sample),
        .i_mode      (r_mode),
        .i_bit_depth (r_bit_depth),
        .o_orig      (orig),
        .o_value     (value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left       <= '0;
            r_upper_left <= '0;
        end else if (s1_adv) begin
            r_left       <= orig;
            r_upper_left <= nb_b;
        end
    end

    // output register
    logic [SAMPLE_W-1:0] r_out_value;
    logic                r_out_eoi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_value <= value;
            r_out_eoi   <= r_s1_pos.last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_value        = r_out_value;
    assign o_end_of_image = r_out_eoi;

    // checks
    a_fwd_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_fwd |-> r_s1_valid)
        else $error("row store bypass flagged without an item in stage 1");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted item did not reach stage 1");

    a_s1_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && !i_out_ready |=> r_s1_valid && $stable(r_s1_addr))
        else $error("stage 1 item lost while output stalled");

    a_plane_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && scan_pos.last |=> scan_pos.first_col && scan_pos.first_row)
        else $error("position did not return to the corner after the last sample");

endmodule
`default_nettype wire
